@@ src/assert_macros.svh @@
// assertion macros used by the top-level rtl file
// real checks in simulation, empty bodies under SYNTHESIS
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ src/sha256_pkg.sv @@
// sha-256 package: round constants, initial chain, rotate helper, shared types
// no dependencies
`timescale 1ns / 1ps
package sha256_pkg;
  localparam int unsigned BlkBytes = 64;
  localparam int unsigned QueueDepth = 4;
  localparam logic [7:0] PadByte = 8'h80;

  // queue entry between front and back
  typedef enum logic [1:0] {
    OP_BLOCK  = 2'd0,
    OP_FINAL  = 2'd1
  } op_t;

  typedef struct packed {
    op_t   op;
    logic  bank;
  } cmd_t;

  function automatic logic [31:0] round_k(input logic [5:0] t);
    logic [31:0] k [64];
    k = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    return k[t];
  endfunction

  function automatic logic [31:0] init_h(input logic [2:0] i);
    logic [31:0] h [8];
    h = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
          32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
    return h[i];
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction
endpackage

@@ src/sha256_stream_hasher.sv @@
// top level of the sha-256 byte stream hasher
// depends on sha256_pkg, sha256_front, sha256_cmdq, sha256_back, sha256_ram
//
//  channel | dir | ports
//  in      | in  | in_valid, in_stall, in_mode, in_data_byte
//  out     | out | out_valid, out_stall, out_digest_word, out_word_index, out_last_word
//
// a byte is taken per cycle while filling into a free block bank with queue
// room; each block is loaded, runs 64 rounds and one add in the back end,
// while the front end fills the other bank; finish pads one byte per cycle
// unless a busy bank or full queue holds it, then eight digest words follow
// out_stall holds the digest word; no clearing pass after reset
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sha256_stream_hasher import sha256_pkg::*; #(
  parameter int unsigned QDepth = QueueDepth
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_mode,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);
  logic       wr_en, cmd_push, cmd_full, cmd_pop, cmd_valid;
  logic       bank_free, bank_free_id, fin_done;
  logic [6:0] wr_addr, rd_addr;
  logic [7:0] wr_data, rd_data;
  cmd_t       push_data, pop_data;

  // request intake and padding
  sha256_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_mode, .in_data_byte,
    .wr_en, .wr_addr, .wr_data, .cmd_push, .cmd_data(push_data), .cmd_full,
    .bank_free, .bank_free_id, .fin_done
  );

  // two 64-byte banks
  sha256_ram #(.Width(8), .Depth(2*BlkBytes)) u_store (
    .clk, .wr_en, .wr_addr, .wr_data, .rd_addr, .rd_data
  );

  sha256_cmdq #(.Depth(QDepth)) u_q (
    .clk, .rst_n, .push(cmd_push), .push_data, .full(cmd_full),
    .pop(cmd_pop), .valid(cmd_valid), .pop_data
  );

  // compression and digest output
  sha256_back u_back (
    .clk, .rst_n, .cmd_valid, .cmd_data(pop_data), .cmd_pop, .rd_addr, .rd_data,
    .bank_free, .bank_free_id, .fin_done, .out_valid, .out_stall,
    .out_digest_word, .out_word_index, .out_last_word
  );

  `ASSERT_IMPL(a_last_idx, clk, rst_n, out_valid && out_last_word, out_word_index == 3'd7,
    "last word flag off index seven")
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid,
    "digest word dropped while stalled")
  `ASSERT_IMPL(a_no_push_full, clk, rst_n, cmd_full, !cmd_push,
    "push into full command queue")
endmodule

@@ src/sha256_ram.sv @@
// generic single-port-write, single-read ram with registered read
// no dependencies
`timescale 1ns / 1ps
module sha256_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(Depth)-1:0] wr_addr,
  input  logic [Width-1:0]         wr_data,
  input  logic [$clog2(Depth)-1:0] rd_addr,
  output logic [Width-1:0]         rd_data
);
  logic [Width-1:0] mem [Depth];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end
endmodule

@@ src/sha256_front.sv @@
// front end: takes bytes and finish requests, fills two block banks, pads
// depends on sha256_pkg and sha256_ram write port signals (drives them)
`timescale 1ns / 1ps
module sha256_front import sha256_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_mode,
  input  logic [7:0]  in_data_byte,
  // byte store write port
  output logic        wr_en,
  output logic [6:0]  wr_addr,
  output logic [7:0]  wr_data,
  // command queue push
  output logic        cmd_push,
  output cmd_t        cmd_data,
  input  logic        cmd_full,
  // bank freed by back end
  input  logic        bank_free,
  input  logic        bank_free_id,
  // finish completion from back end
  input  logic        fin_done
);
  typedef enum logic [3:0] {
    S_FILL = 4'b0001,
    S_PAD  = 4'b0010,
    S_LEN  = 4'b0100,
    S_WAIT = 4'b1000
  } fst_t;

  fst_t        st_r, st_nxt;
  logic [5:0]  fill_r, fill_nxt;
  logic [60:0] total_r, total_nxt;
  logic        bank_r, bank_nxt;
  logic [1:0]  busy_r, busy_nxt;
  logic        first_r, first_nxt;
  logic [63:0] bits;
  logic        take;

  assign bits = {total_r, 3'b000};
  // accept only while filling into a free bank with queue room
  assign in_stall = !(st_r == S_FILL && !busy_r[bank_r] && !cmd_full);
  assign take = in_valid && !in_stall;

  // fill, pad and length sequencing
  always_comb begin
    st_nxt = st_r;
    fill_nxt = fill_r;
    total_nxt = total_r;
    bank_nxt = bank_r;
    busy_nxt = busy_r;
    first_nxt = first_r;
    wr_en = 1'b0;
    wr_addr = {bank_r, fill_r};
    wr_data = in_data_byte;
    cmd_push = 1'b0;
    cmd_data = '{op: OP_BLOCK, bank: bank_r};
    if (bank_free) busy_nxt[bank_free_id] = 1'b0;
    unique case (st_r)
      S_FILL: begin
        if (take && !in_mode) begin
          wr_en = 1'b1;
          fill_nxt = fill_r + 6'd1;
          total_nxt = total_r + 61'd1;
          if (fill_r == 6'd63) begin
            cmd_push = 1'b1;
            busy_nxt[bank_r] = 1'b1;
            bank_nxt = !bank_r;
          end
        end else if (take) begin
          wr_en = 1'b1;
          wr_data = PadByte;
          fill_nxt = fill_r + 6'd1;
          // length field still fits in this block
          first_nxt = (fill_r < 6'd56);
          st_nxt = S_PAD;
        end
      end
      S_PAD: begin
        // zero fill up to the length field or end of block
        if (!busy_r[bank_r] && !cmd_full) begin
          if (fill_r == 6'd56 && first_r) begin
            st_nxt = S_LEN;
          end else if (fill_r == 6'd0 && !first_r) begin
            // block wrapped: hand it off, continue in other bank
            cmd_push = 1'b1;
            busy_nxt[bank_r] = 1'b1;
            bank_nxt = !bank_r;
            first_nxt = 1'b1;
          end else begin
            wr_en = 1'b1;
            wr_data = 8'h00;
            fill_nxt = fill_r + 6'd1;
          end
        end
      end
      S_LEN: begin
        if (!cmd_full) begin
          wr_en = 1'b1;
          wr_data = bits[63 - 8*fill_r[2:0] -: 8];
          fill_nxt = fill_r + 6'd1;
          if (fill_r == 6'd63) begin
            cmd_push = 1'b1;
            cmd_data = '{op: OP_FINAL, bank: bank_r};
            busy_nxt[bank_r] = 1'b1;
            bank_nxt = !bank_r;
            st_nxt = S_WAIT;
          end
        end
      end
      S_WAIT: begin
        if (fin_done) begin
          total_nxt = '0;
          st_nxt = S_FILL;
        end
      end
      default: st_nxt = S_FILL;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_FILL;
      fill_r <= '0;
      total_r <= '0;
      bank_r <= 1'b0;
      busy_r <= '0;
      first_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      fill_r <= fill_nxt;
      total_r <= total_nxt;
      bank_r <= bank_nxt;
      busy_r <= busy_nxt;
      first_r <= first_nxt;
    end
  end
endmodule

@@ src/sha256_back.sv @@
// back end: compresses queued blocks in 64 rounds and emits the digest
// depends on sha256_pkg; reads the byte store through its read port
`timescale 1ns / 1ps
module sha256_back import sha256_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cmd_valid,
  input  cmd_t        cmd_data,
  output logic        cmd_pop,
  output logic [6:0]  rd_addr,
  input  logic [7:0]  rd_data,
  output logic        bank_free,
  output logic        bank_free_id,
  output logic        fin_done,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);
  typedef enum logic [4:0] {
    B_IDLE = 5'b00001,
    B_LOAD = 5'b00010,
    B_RND  = 5'b00100,
    B_ADD  = 5'b01000,
    B_OUT  = 5'b10000
  } bst_t;

  bst_t         st_r, st_nxt;
  logic [31:0]  h_r [8];
  logic [31:0]  v_r [8];
  logic [31:0]  w_r [16];
  logic [6:0]   cnt_r;
  cmd_t         cmd_r;
  logic [2:0]   oidx_r;
  logic [31:0]  wt, t1, t2, s0, s1;
  logic [31:0]  ws0, ws1, wnew;

  // message schedule and one round
  assign ws0 = rotr(w_r[1], 7) ^ rotr(w_r[1], 18) ^ (w_r[1] >> 3);
  assign ws1 = rotr(w_r[14], 17) ^ rotr(w_r[14], 19) ^ (w_r[14] >> 10);
  assign wnew = ws1 + w_r[9] + ws0 + w_r[0];
  assign wt = w_r[0];
  assign s1 = rotr(v_r[4], 6) ^ rotr(v_r[4], 11) ^ rotr(v_r[4], 25);
  assign s0 = rotr(v_r[0], 2) ^ rotr(v_r[0], 13) ^ rotr(v_r[0], 22);
  assign t1 = v_r[7] + s1 + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]))
            + round_k(cnt_r[5:0]) + wt;
  assign t2 = s0 + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));

  assign rd_addr = {cmd_valid && st_r == B_IDLE ? cmd_data.bank : cmd_r.bank,
                    cnt_r[5:0]};
  assign cmd_pop = (st_r == B_IDLE) && cmd_valid;
  assign bank_free = (st_r == B_RND) && cnt_r == 7'd0;
  assign bank_free_id = cmd_r.bank;
  assign fin_done = (st_r == B_OUT) && !out_stall && oidx_r == 3'd7;
  assign out_valid = (st_r == B_OUT);
  assign out_digest_word = h_r[oidx_r];
  assign out_word_index = oidx_r;
  assign out_last_word = (oidx_r == 3'd7);

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      B_IDLE: if (cmd_valid) st_nxt = B_LOAD;
      B_LOAD: if (cnt_r == 7'd64) st_nxt = B_RND;
      B_RND:  if (cnt_r == 7'd63) st_nxt = B_ADD;
      B_ADD:  st_nxt = (cmd_r.op == OP_FINAL) ? B_OUT : B_IDLE;
      B_OUT:  if (!out_stall && oidx_r == 3'd7) st_nxt = B_IDLE;
      default: st_nxt = B_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= B_IDLE;
      cnt_r <= '0;
      oidx_r <= '0;
      for (int i = 0; i < 8; i++) h_r[i] <= init_h(3'(i));
    end else begin
      st_r <= st_nxt;
      unique case (st_r)
        B_IDLE: cnt_r <= cmd_valid ? 7'd1 : 7'd0;
        B_LOAD: cnt_r <= (cnt_r == 7'd64) ? 7'd0 : cnt_r + 7'd1;
        B_RND:  cnt_r <= cnt_r + 7'd1;
        default: cnt_r <= '0;
      endcase
      if (st_r == B_ADD)
        for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
      if (st_r == B_OUT && !out_stall) begin
        oidx_r <= oidx_r + 3'd1;
        if (oidx_r == 3'd7)
          for (int i = 0; i < 8; i++) h_r[i] <= init_h(3'(i));
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (st_r == B_IDLE && cmd_valid) cmd_r <= cmd_data;
    if (st_r == B_LOAD) begin
      // byte arriving is index cnt_r-1; a finished word moves down the
      // window when the first byte of the next word arrives
      w_r[15] <= {w_r[15][23:0], rd_data};
      if (cnt_r[1:0] == 2'd1)
        for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
      if (cnt_r == 7'd64)
        for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
    end
    if (st_r == B_RND) begin
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
      w_r[15] <= wnew;
      v_r[7] <= v_r[6];
      v_r[6] <= v_r[5];
      v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2];
      v_r[2] <= v_r[1];
      v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
    end
  end
endmodule

@@ src/sha256_cmdq.sv @@
// short command queue between front and back ends
// depends on sha256_pkg
`timescale 1ns / 1ps
module sha256_cmdq import sha256_pkg::*; #(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output logic valid,
  output cmd_t pop_data
);
  localparam int unsigned Aw = $clog2(Depth);
  cmd_t          q_r [Depth];
  logic [Aw-1:0] wp_r, rp_r;
  logic [Aw:0]   cnt_r;

  assign full = (cnt_r == (Aw+1)'(Depth));
  assign valid = (cnt_r != '0);
  assign pop_data = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == Aw'(Depth-1)) ? '0 : wp_r + 1'b1;
      if (pop) rp_r <= (rp_r == Aw'(Depth-1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (Aw+1)'(push) - (Aw+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= push_data;
  end
endmodule
